### sv/stfa_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the slot table allocator.
// No dependencies; used by the top level, the checker and the testbench.
package stfa_pkg;

    localparam int MAX_SLOTS_DEF    = 64;
    localparam int ELEMENT_BITS_DEF = 32;
    localparam int MIN_CAP          = 4;

    localparam int OP_BITS     = 2;
    localparam int INDEX_BITS  = 6;
    localparam int DATA_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 7;

    localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [INDEX_BITS-1:0] slot_index;
        logic [DATA_BITS-1:0]  element_in;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [DATA_BITS-1:0]   element_out;
        logic [COUNT_BITS-1:0]  used_count;
        logic [COUNT_BITS-1:0]  capacity_now;
    } rsp_item_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } state_t;

endpackage

### sv/stfa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/stfa_slot_scan.sv
`timescale 1ns / 1ps
// Priority encoders over the occupied map: lowest free slot and highest
// occupied slot. Depends on nothing but its parameter.
module stfa_slot_scan #(
    parameter int MAX_SLOTS = 64
) (
    input  logic [MAX_SLOTS-1:0]         free_map,
    input  logic [MAX_SLOTS-1:0]         occ_map,
    output logic [$clog2(MAX_SLOTS)-1:0] first_free,
    output logic                         free_found,
    output logic [$clog2(MAX_SLOTS)-1:0] top_slot,
    output logic                         top_found
);

    localparam int IW = $clog2(MAX_SLOTS);

    logic [MAX_SLOTS-1:0] free_vec;
    logic [MAX_SLOTS-1:0] free_low;
    logic [MAX_SLOTS-1:0] occ_rev;
    logic [MAX_SLOTS-1:0] occ_low;
    logic [IW-1:0]        rev_pos;

    // isolate lowest set bit, then OR together the index of that one bit
    always_comb
    begin
        free_vec = ~free_map;
        free_low = free_vec & (~free_vec + MAX_SLOTS'(1));
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            occ_rev[i] = occ_map[MAX_SLOTS-1-i];
        end
        occ_low = occ_rev & (~occ_rev + MAX_SLOTS'(1));
        first_free = '0;
        rev_pos    = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (free_low[i])
            begin
                first_free = first_free | IW'(i);
            end
            if (occ_low[i])
            begin
                rev_pos = rev_pos | IW'(i);
            end
        end
        free_found = |free_vec;
        top_found  = |occ_map;
        top_slot   = IW'(MAX_SLOTS - 1) - rev_pos;
    end

endmodule

### sv/slot_table_first_free_alloc.sv
`timescale 1ns / 1ps
// Top level of the slot table allocator: control, occupied map, counters.
// Depends on stfa_pkg, stfa_ram and stfa_slot_scan.
//
//   channel  valid      stall      payload  direction
//   request  req_valid  req_stall  req      in
//   result   rsp_valid  rsp_stall  rsp      out
//
// In each transfer the accept cycle issues the data RAM read, and the work
// state then scans the occupied map, writes the RAM and updates state.
// The RAM read-modify-write sets this split; a write always lands before
// the next request is accepted, so no forwarding is needed.
// Reset clears the occupied map, count and capacity at once; no clearing pass.
// A stalled result holds the block in its work cycle; one result may wait in
// the output register while the next request is accepted.
module slot_table_first_free_alloc #(
    parameter int MAX_SLOTS    = stfa_pkg::MAX_SLOTS_DEF,
    parameter int ELEMENT_BITS = stfa_pkg::ELEMENT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  stfa_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output stfa_pkg::rsp_item_t rsp
);

    localparam int IW  = $clog2(MAX_SLOTS);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int XW  = (CW > stfa_pkg::INDEX_BITS) ? CW : stfa_pkg::INDEX_BITS;

    stfa_pkg::state_t state_reg, state_next;

    logic [stfa_pkg::OP_BITS-1:0]    op_reg;
    logic [stfa_pkg::INDEX_BITS-1:0] idx_reg;
    logic [ELEMENT_BITS-1:0]         elem_reg;

    logic [MAX_SLOTS-1:0] map_reg, map_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        cap_reg, cap_next;

    stfa_pkg::rsp_item_t rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                    accept;
    logic                    commit;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [ELEMENT_BITS-1:0] wr_data;
    logic [ELEMENT_BITS-1:0] rd_data;

    logic [IW-1:0]        idx_sel;
    logic                 idx_ok;
    logic [MAX_SLOTS-1:0] idx_bit;
    logic [MAX_SLOTS-1:0] occ_cleared;

    logic [IW-1:0] first_free;
    logic          free_found;
    logic [IW-1:0] top_slot;
    logic          top_found;

    logic [CW:0]   cap_dbl;
    logic [CW-1:0] cap_grown;
    logic [CW-1:0] count_dec;
    logic [CW-1:0] top_p1;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != stfa_pkg::S_IDLE);
    assign commit    = (state_reg == stfa_pkg::S_WORK) && (!rsp_valid_reg || !rsp_stall);

    stfa_ram #(
        .WIDTH(ELEMENT_BITS),
        .DEPTH(MAX_SLOTS)
    ) u_slot_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (accept),
        .rd_addr(IW'(req.slot_index)),
        .rd_data(rd_data)
    );

    stfa_slot_scan #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_scan (
        .free_map  (map_reg),
        .occ_map   (occ_cleared),
        .first_free(first_free),
        .free_found(free_found),
        .top_slot  (top_slot),
        .top_found (top_found)
    );

    // slot_index may be narrower or wider than the table index
    always_comb
    begin
        idx_sel     = IW'(idx_reg);
        idx_ok      = (XW'(idx_reg) < XW'(cap_reg)) && map_reg[idx_sel];
        idx_bit     = MAX_SLOTS'(1) << idx_sel;
        occ_cleared = map_reg & ~idx_bit;
        cap_dbl     = {cap_reg, 1'b0};
        if (cap_reg == '0)
        begin
            cap_grown = CW'(stfa_pkg::MIN_CAP);
        end
        else if (cap_dbl > (CW + 1)'(MAX_SLOTS))
        begin
            cap_grown = CW'(MAX_SLOTS);
        end
        else
        begin
            cap_grown = cap_dbl[CW-1:0];
        end
        count_dec = count_reg - CW'(1);
        top_p1    = CW'(top_slot) + CW'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        map_next       = map_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_sel;
        wr_data        = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            stfa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = stfa_pkg::S_WORK;
                end
            end
            stfa_pkg::S_WORK:
            begin
                if (commit)
                begin
                    rsp_next.status      = stfa_pkg::ST_OK;
                    rsp_next.element_out = '0;
                    unique case (op_reg)
                        stfa_pkg::OP_ADD:
                        begin
                            if (free_found && (CW'(first_free) < cap_reg))
                            begin
                                wr_en   = 1'b1;
                                wr_addr = first_free;
                            end
                            else if (cap_reg >= CW'(MAX_SLOTS))
                            begin
                                rsp_next.status = stfa_pkg::ST_FULL;
                            end
                            else
                            begin
                                // slots at and above the capacity are free
                                wr_en    = 1'b1;
                                wr_addr  = cap_reg[IW-1:0];
                                cap_next = cap_grown;
                            end
                            if (wr_en)
                            begin
                                wr_data           = elem_reg;
                                map_next[wr_addr] = 1'b1;
                                count_next        = count_reg + CW'(1);
                            end
                        end
                        stfa_pkg::OP_DELETE:
                        begin
                            if (!idx_ok)
                            begin
                                rsp_next.status = stfa_pkg::ST_BAD;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                map_next   = occ_cleared;
                                count_next = count_dec;
                                if ((cap_reg > CW'(stfa_pkg::MIN_CAP)) &&
                                    (count_dec < (cap_reg >> 2)))
                                begin
                                    if (!top_found)
                                    begin
                                        cap_next   = '0;
                                        count_next = '0;
                                    end
                                    else if (top_p1 < CW'(stfa_pkg::MIN_CAP))
                                    begin
                                        cap_next = CW'(stfa_pkg::MIN_CAP);
                                    end
                                    else
                                    begin
                                        cap_next = top_p1;
                                    end
                                end
                            end
                        end
                        stfa_pkg::OP_READ:
                        begin
                            if (!idx_ok)
                            begin
                                rsp_next.status = stfa_pkg::ST_BAD;
                            end
                            else
                            begin
                                rsp_next.element_out = stfa_pkg::DATA_BITS'(rd_data);
                            end
                        end
                        default:
                        begin
                            rsp_next.status = stfa_pkg::ST_BAD;
                        end
                    endcase
                    rsp_next.used_count   = stfa_pkg::COUNT_BITS'(count_next);
                    rsp_next.capacity_now = stfa_pkg::COUNT_BITS'(cap_next);
                    rsp_valid_next        = 1'b1;
                    state_next            = stfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stfa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stfa_pkg::S_IDLE;
            map_reg       <= '0;
            count_reg     <= '0;
            cap_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            idx_reg  <= req.slot_index;
            elem_reg <= ELEMENT_BITS'(req.element_in);
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### dv/stfa_table_check.sv
`timescale 1ns / 1ps
// Checker for the slot table allocator: watches both channels, keeps its own
// copy of the table, predicts each result and compares it field by field.
// Depends on stfa_pkg.
module stfa_table_check
    import stfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_item_t   req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_item_t   rsp,
    output int unsigned fail_count,
    output int unsigned outstanding
);

    localparam int TABLE_SLOTS = MAX_SLOTS_DEF;
    localparam int GROW_FACTOR = 2;

    // shadow table
    logic [DATA_BITS-1:0] shadow_data [TABLE_SLOTS];
    bit                   shadow_occ  [TABLE_SLOTS];
    int unsigned          shadow_count;
    int unsigned          shadow_cap;

    rsp_item_t pending_results[$];

    initial
    begin
        fail_count   = 0;
        outstanding  = 0;
        shadow_count = 0;
        shadow_cap   = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            shadow_data[i] = '0;
            shadow_occ[i]  = 1'b0;
        end
    end

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        fail_count++;
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    endtask

    // Capacity falls to the highest occupied slot plus one, at least MIN_CAP,
    // or to zero once nothing is occupied.
    function automatic void shrink_table();
        int unsigned top_slot;
        top_slot = 0;
        for (int i = shadow_cap; i > 0; i--)
        begin
            if (shadow_occ[i-1])
            begin
                top_slot = i;
                break;
            end
        end
        if (top_slot == 0)
        begin
            shadow_cap   = 0;
            shadow_count = 0;
        end
        else
            shadow_cap = (top_slot < MIN_CAP) ? MIN_CAP : top_slot;
    endfunction

    function automatic rsp_item_t apply_request(input req_item_t r);
        rsp_item_t   o;
        int unsigned pos;
        int unsigned grown;
        o        = '0;
        o.status = ST_OK;
        case (r.op)
            OP_ADD:
            begin
                pos = 0;
                while (pos < shadow_cap && shadow_occ[pos])
                    pos++;
                if (pos >= shadow_cap)
                begin
                    if (shadow_cap >= TABLE_SLOTS)
                        o.status = ST_FULL;
                    else
                    begin
                        grown = (shadow_cap == 0) ? MIN_CAP : shadow_cap * GROW_FACTOR;
                        if (grown > TABLE_SLOTS)
                            grown = TABLE_SLOTS;
                        pos        = shadow_cap;
                        shadow_cap = grown;
                    end
                end
                if (o.status == ST_OK)
                begin
                    shadow_data[pos] = r.element_in;
                    shadow_occ[pos]  = 1'b1;
                    shadow_count++;
                end
            end
            OP_DELETE, OP_READ:
            begin
                if (r.slot_index >= shadow_cap || !shadow_occ[r.slot_index])
                    o.status = ST_BAD;
                else if (r.op == OP_READ)
                    o.element_out = shadow_data[r.slot_index];
                else
                begin
                    shadow_data[r.slot_index] = '0;
                    shadow_occ[r.slot_index]  = 1'b0;
                    if (shadow_count > 0)
                        shadow_count--;
                    if (shadow_cap > MIN_CAP && shadow_count < shadow_cap / 4)
                        shrink_table();
                end
            end
            default:
                o.status = ST_BAD;
        endcase
        o.used_count   = shadow_count[COUNT_BITS-1:0];
        o.capacity_now = shadow_cap[COUNT_BITS-1:0];
        return o;
    endfunction

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n)
        begin
            // a result is always older than a request taken at the same edge
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                    report("unexpected result", rsp.element_out, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.status !== want.status)
                        report("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.element_out !== want.element_out)
                        report("element_out", rsp.element_out, want.element_out);
                    if (rsp.used_count !== want.used_count)
                        report("used_count", 32'(rsp.used_count), 32'(want.used_count));
                    if (rsp.capacity_now !== want.capacity_now)
                        report("capacity_now", 32'(rsp.capacity_now),
                               32'(want.capacity_now));
                end
            end
            if (req_valid && !req_stall)
                pending_results.push_back(apply_request(req));
            outstanding = pending_results.size();
        end
    end

endmodule

### dv/slot_table_first_free_alloc_tb.sv
`timescale 1ns / 1ps
// Top of the slot table allocator testbench: clock, reset, request stimulus
// and result stall; depends on stfa_pkg, stfa_table_check and the block.
module slot_table_first_free_alloc_tb;
    import stfa_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 23;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_item_t   req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_item_t   rsp;
    bit          steady    = 1'b0;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycles    = 0;

    always #6 clk = ~clk;

    slot_table_first_free_alloc u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    stfa_table_check u_table_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(negedge clk)
        rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("slot_table_first_free_alloc test failed");
            $finish;
        end
    end

    function automatic req_item_t make_item(input logic [OP_BITS-1:0] op,
                                            input int unsigned idx,
                                            input logic [DATA_BITS-1:0] elem);
        req_item_t it;
        it.op         = op;
        it.slot_index = idx[INDEX_BITS-1:0];
        it.element_in = elem;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input req_item_t it);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic req_item_t random_item(input mix_mode_t mode);
        int unsigned pick;
        int unsigned bound;
        logic [DATA_BITS-1:0] elem;
        logic [OP_BITS-1:0]   op;
        pick  = $urandom_range(0, 99);
        bound = (4 << $urandom_range(0, 4)) - 1;
        case ($urandom_range(0, 9))
            0:       elem = '0;
            1:       elem = '1;
            default: elem = $urandom;
        endcase
        if (pick < 3)
            op = OP_UNUSED;
        else
            case (mode)
                MODE_FILL:  op = (pick < 85) ? OP_ADD : (pick < 95) ? OP_READ : OP_DELETE;
                MODE_DRAIN: op = (pick < 75) ? OP_DELETE : (pick < 90) ? OP_READ : OP_ADD;
                default:    op = (pick < 40) ? OP_ADD : (pick < 70) ? OP_DELETE : OP_READ;
            endcase
        return make_item(op, $urandom_range(0, bound), elem);
    endfunction

    initial
    begin
        req_item_t   directed[$];
        mix_mode_t   mode;
        int unsigned phase_left;
        int unsigned sent;

        // empty table, then fill past the first growth, delete down until
        // the shrink rule trims capacity and finally empties the table
        directed.push_back(make_item(OP_READ,   0,  '0));
        directed.push_back(make_item(OP_DELETE, 0,  '0));
        directed.push_back(make_item(OP_ADD,    63, 32'h0000_0000));
        directed.push_back(make_item(OP_ADD,    0,  32'hFFFF_FFFF));
        directed.push_back(make_item(OP_READ,   0,  '1));
        directed.push_back(make_item(OP_READ,   1,  '0));
        directed.push_back(make_item(OP_READ,   63, '0));
        directed.push_back(make_item(OP_READ,   2,  '0));
        directed.push_back(make_item(OP_DELETE, 3,  '0));
        directed.push_back(make_item(OP_UNUSED, 63, 32'hFFFF_FFFF));
        directed.push_back(make_item(OP_ADD,    42, 32'hA5A5_A5A5));
        directed.push_back(make_item(OP_ADD,    21, 32'h5A5A_5A5A));
        directed.push_back(make_item(OP_ADD,    0,  32'h8000_0001));
        directed.push_back(make_item(OP_DELETE, 1,  '0));
        directed.push_back(make_item(OP_ADD,    0,  32'h1234_5678));
        directed.push_back(make_item(OP_READ,   1,  '0));
        for (int i = 0; i < 4; i++)
            directed.push_back(make_item(OP_DELETE, i, '0));
        directed.push_back(make_item(OP_READ,   4,  '0));
        directed.push_back(make_item(OP_READ,   5,  '0));
        directed.push_back(make_item(OP_DELETE, 4,  '0));
        directed.push_back(make_item(OP_READ,   4,  '0));
        directed.push_back(make_item(OP_UNUSED, 0,  '0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_item(directed[i]);

        // phases biased toward filling or draining so the table keeps
        // crossing growth, full and shrink boundaries
        mode       = MODE_FILL;
        phase_left = 120;
        for (sent = 0; sent < RANDOM_ITEMS; sent++)
        begin
            steady = (sent >= 500 && sent < 800);
            if (phase_left == 0)
            begin
                mode       = mix_mode_t'($urandom_range(0, 2));
                phase_left = $urandom_range(50, 150);
            end
            phase_left--;
            send_item(random_item(mode));
        end
        req_valid <= 1'b0;
        steady = 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("slot_table_first_free_alloc test passed");
        else
            $display("slot_table_first_free_alloc test failed");
        $finish;
    end

endmodule
